@@ src/lcema_pkg.sv @@
package lcema_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  // word index of each configuration register
  localparam logic [REG_IDX_W-1:0] REG_EMA_WEIGHT = REG_IDX_W'(0);

  typedef enum logic [1:0] {
    CMD_MEASURE = 2'd0,
    CMD_LEARN   = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    OP_MEASURE,
    OP_LEARN,
    OP_RESTART
  } op_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

endpackage

@@ src/lcema_front.sv @@
module lcema_front #(
  parameter int SAMPLE_BITS = lcema_pkg::SAMPLE_BITS_DEF,
  parameter int DEPTH       = lcema_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic [1:0]                    cmd,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          take,
  output lcema_pkg::q_stat_t            stat,
  output lcema_pkg::op_t                head_op,
  output logic signed [SAMPLE_BITS-1:0] head_sample
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lcema_pkg::op_t              op_mem     [DEPTH];
  logic signed [SAMPLE_BITS-1:0] sample_mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  lcema_pkg::op_t   in_op;
  logic             push_ok, take_ok;

  // cmd 3 is unused and runs as a measure
  always_comb begin
    case (cmd)
      lcema_pkg::CMD_LEARN:   in_op = lcema_pkg::OP_LEARN;
      lcema_pkg::CMD_RESTART: in_op = lcema_pkg::OP_RESTART;
      default:                in_op = lcema_pkg::OP_MEASURE;
    endcase
  end

  assign stat.full      = (cnt_r == CNT_W'(DEPTH));
  assign stat.not_empty = (cnt_r != '0);
  assign push_ok        = push && !stat.full;
  assign take_ok        = take && stat.not_empty;

  assign head_op     = op_mem[rd_ptr_r];
  assign head_sample = sample_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      op_mem[wr_ptr_r]     <= in_op;
      sample_mem[wr_ptr_r] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (take_ok) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_ok && !take_ok) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (take_ok && !push_ok) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ src/lcema_back.sv @@
module lcema_back #(
  parameter int SAMPLE_BITS = lcema_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = lcema_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lcema_pkg::q_stat_t            stat,
  output logic                          take,
  input  lcema_pkg::op_t                head_op,
  input  logic signed [SAMPLE_BITS-1:0] head_sample,
  input  logic [FRAC_BITS:0]            weight,
  input  logic                          pop,
  output logic                          empty,
  output logic signed [SAMPLE_BITS-1:0] filtered,
  output logic [FRAC_BITS:0]            normalized,
  output logic                          range_valid
);

  localparam int S     = SAMPLE_BITS;
  localparam int F     = FRAC_BITS;
  localparam int A     = S + F + 1;      // accumulator
  localparam int D     = A + 1;          // difference
  localparam int P     = D + F + 1;      // product
  localparam int CNT_W = $clog2(F + 1);

  localparam logic [F:0] ONE  = {1'b1, {F{1'b0}}};
  localparam logic [F:0] HALF = {2'b01, {(F-1){1'b0}}};
  localparam logic signed [S-1:0] S_MAX = {1'b0, {(S-1){1'b1}}};
  localparam logic signed [S-1:0] S_MIN = {1'b1, {(S-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_FILT,
    ST_RANGE,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t                state_r;
  lcema_pkg::op_t        op_r;
  logic signed [A-1:0]   acc_r;
  logic                  seeded_r;
  logic signed [S-1:0]   min_r, max_r;
  logic signed [D-1:0]   diff_r;
  logic [F:0]            wbits_r;
  logic signed [P-1:0]   prod_r;
  logic [CNT_W-1:0]      cnt_r;
  logic signed [S-1:0]   filt_r;
  logic [S:0]            rem_r;
  logic [S-1:0]          den_r;
  logic [F:0]            quo_r;
  logic                  out_valid_r;
  logic signed [S-1:0]   out_filt_r;
  logic [F:0]            out_norm_r;
  logic                  out_rv_r;

  logic                  restart;
  logic                  seeded_eff;
  logic signed [A-1:0]   target, acc_base;
  logic [F:0]            w_cl;
  logic signed [P-1:0]   diff_ext, acc_sum;
  logic signed [A-1:0]   acc_q;
  logic                  round_up;
  logic signed [S-1:0]   clamped;
  logic signed [S:0]     num, span;
  logic [S:0]            trial;
  logic                  ge;
  logic                  out_load;

  assign take = (state_r == ST_IDLE) && stat.not_empty;

  // seeding: acc = sample * ONE, so the update leaves it unchanged
  assign restart    = (head_op == lcema_pkg::OP_RESTART);
  assign seeded_eff = seeded_r && !restart;
  assign target     = {head_sample[S-1], head_sample, {F{1'b0}}};
  assign acc_base   = seeded_eff ? acc_r : target;
  assign w_cl       = (weight[F] && |weight[F-1:0]) ? ONE : weight;

  assign diff_ext = {{(P-D){diff_r[D-1]}}, diff_r};
  // product >>> F is the exact floor of w * diff / ONE
  assign acc_sum  = $signed({{(P-A){acc_r[A-1]}}, acc_r}) + (prod_r >>> F);

  // truncate toward zero
  assign acc_q    = acc_r >>> F;
  assign round_up = acc_r[A-1] && |acc_r[F-1:0];

  assign clamped = (filt_r < min_r) ? min_r : ((filt_r > max_r) ? max_r : filt_r);
  assign num     = {clamped[S-1], clamped} - {min_r[S-1], min_r};
  assign span    = {max_r[S-1], max_r} - {min_r[S-1], min_r};

  // restoring division, one quotient bit per cycle, weight ONE first
  assign trial = (cnt_r == '0) ? rem_r : {rem_r[S-1:0], 1'b0};
  assign ge    = (trial >= {1'b0, den_r});

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= '0;
      seeded_r    <= 1'b0;
      min_r       <= S_MAX;
      max_r       <= S_MIN;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (stat.not_empty) begin
            op_r     <= head_op;
            acc_r    <= acc_base;
            seeded_r <= 1'b1;
            diff_r   <= {target[A-1], target} - {acc_base[A-1], acc_base};
            wbits_r  <= w_cl;
            prod_r   <= '0;
            cnt_r    <= '0;
            if (restart) begin
              min_r <= S_MAX;
              max_r <= S_MIN;
            end
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          // MSB-first shift-add over the weight bits
          prod_r  <= (prod_r <<< 1) + (wbits_r[F] ? diff_ext : '0);
          wbits_r <= {wbits_r[F-1:0], 1'b0};
          if (cnt_r == CNT_W'(F)) begin
            cnt_r   <= '0;
            state_r <= ST_ADD;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_ADD: begin
          acc_r   <= acc_sum[A-1:0];
          state_r <= ST_FILT;
        end
        ST_FILT: begin
          filt_r  <= S'(acc_q + A'(round_up));
          state_r <= ST_RANGE;
        end
        ST_RANGE: begin
          if (op_r != lcema_pkg::OP_MEASURE) begin
            if (filt_r < min_r) min_r <= filt_r;
            if (filt_r > max_r) max_r <= filt_r;
            quo_r   <= '0;
            state_r <= ST_DONE;
          end else if (max_r <= min_r) begin
            quo_r   <= HALF;
            state_r <= ST_DONE;
          end else begin
            rem_r   <= {1'b0, num[S-1:0]};
            den_r   <= span[S-1:0];
            quo_r   <= '0;
            cnt_r   <= '0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r <= ge ? (trial - {1'b0, den_r}) : trial;
          quo_r <= {quo_r[F-1:0], ge};
          if (cnt_r == CNT_W'(F)) begin
            cnt_r   <= '0;
            state_r <= ST_DONE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_filt_r  <= filt_r;
            out_norm_r  <= quo_r;
            out_rv_r    <= (max_r > min_r);
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign empty       = !out_valid_r;
  assign filtered    = out_filt_r;
  assign normalized  = out_norm_r;
  assign range_valid = out_rv_r;

endmodule

@@ src/load_cell_ema_range_normalizer.sv @@
// Each item passes from the input queue through the back end states: the
// shift-add multiply, the accumulator add, the rounded filter output, the
// range step and, for a measure item with a valid range only, the restoring
// divide; the back end takes no new item until its result is loaded out.
// A two-entry queue takes new items while the back end is busy.
// Reset (rst_n low, synchronous): queues empty, filter unseeded, range empty.
module load_cell_ema_range_normalizer #(
  parameter int SAMPLE_BITS = lcema_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = lcema_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = lcema_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic [1:0]                          in_cmd,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [SAMPLE_BITS-1:0]       out_filtered,
  output logic [FRAC_BITS:0]                  out_normalized,
  output logic                                out_range_valid,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lcema_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [lcema_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [lcema_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready
);

  localparam logic [FRAC_BITS:0] W_RESET =
    (FRAC_BITS+1)'(((1 << FRAC_BITS) + 5) / 10);

  logic [FRAC_BITS:0]            weight_r;
  logic                          reg_hit;
  lcema_pkg::q_stat_t            stat;
  lcema_pkg::op_t                head_op;
  logic signed [SAMPLE_BITS-1:0] head_sample;
  logic                          take;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[lcema_pkg::APB_ADDR_W-1:2] == lcema_pkg::REG_EMA_WEIGHT);
  assign prdata  = reg_hit ? lcema_pkg::APB_DATA_W'(weight_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= W_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      weight_r <= pwdata[FRAC_BITS:0];
    end
  end

  assign full = stat.full;

  lcema_front #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .DEPTH      (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .cmd        (in_cmd),
    .sample     (in_sample),
    .take       (take),
    .stat       (stat),
    .head_op    (head_op),
    .head_sample(head_sample)
  );

  lcema_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .stat       (stat),
    .take       (take),
    .head_op    (head_op),
    .head_sample(head_sample),
    .weight     (weight_r),
    .pop        (pop),
    .empty      (empty),
    .filtered   (out_filtered),
    .normalized (out_normalized),
    .range_valid(out_range_valid)
  );

endmodule

@@ src/lcema_checker.sv @@
module lcema_checker #(
  parameter int SAMPLE_BITS = lcema_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = lcema_pkg::FRAC_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          push,
  input logic                          full,
  input logic                          empty,
  input logic                          pop,
  input logic signed [SAMPLE_BITS-1:0] out_filtered,
  input logic [FRAC_BITS:0]            out_normalized,
  input logic                          out_range_valid
);

  localparam logic [FRAC_BITS:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS:0] HALF = {2'b01, {(FRAC_BITS-1){1'b0}}};

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_norm_max: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_normalized <= ONE)
    else $error("normalized above one");

  a_norm_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_range_valid) |-> (out_normalized == HALF || out_normalized == '0))
    else $error("invalid range must give half or zero");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_filtered) && $stable(out_normalized)))
    else $error("stalled item changed");

  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(full) |-> $past(push))
    else $error("input queue filled without push");

endmodule

bind load_cell_ema_range_normalizer lcema_checker #(
  .SAMPLE_BITS(SAMPLE_BITS),
  .FRAC_BITS  (FRAC_BITS)
) u_lcema_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .push           (push),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .out_filtered   (out_filtered),
  .out_normalized (out_normalized),
  .out_range_valid(out_range_valid)
);
